>>> sv/hbridge_motor_duty_regulator_core_assert.svh
// Assertion macros for the duty regulator checker.
// No dependencies; included by the checker file.
`ifndef HBRIDGE_MOTOR_DUTY_REGULATOR_CORE_ASSERT_SVH
`define HBRIDGE_MOTOR_DUTY_REGULATOR_CORE_ASSERT_SVH

// same-cycle implication
`define HMDR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HMDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/hmdr_pkg.sv
// Shared types and constants of the H-bridge duty regulator.
// No dependencies.
`timescale 1ns / 1ps

package hmdr_pkg;

  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SLEW_W     = 9;
  localparam int SLEW_FRAC  = 8;
  localparam int SLEW_ONE   = 1 << SLEW_FRAC;
  localparam int SLEW_RESET = 256;
  localparam int SWITCH_W   = 16;
  localparam int SWITCH_RESET = 100;
  // growth of the scale numerator (x9) and denominator (x10)
  localparam int SCALE_GROW = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_DISABLE = 2'd0,
    MODE_BRAKE   = 2'd1,
    MODE_FORWARD = 2'd2,
    MODE_REVERSE = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_REGULATED = 2'd0,
    ST_CUTOFF    = 2'd1,
    ST_SWITCHING = 2'd2,
    ST_LIMITED   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUTOFF   = 3'd0,
    CFG_LIMIT    = 3'd1,
    CFG_MIN_DUTY = 3'd2,
    CFG_MAX_DUTY = 3'd3,
    CFG_SLEW     = 3'd4,
    CFG_SWITCH   = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_DECIDE,
    SEQ_SCALE_MUL,
    SEQ_SCALE_NUM,
    SEQ_DIV_START,
    SEQ_DIV_WAIT,
    SEQ_SLEW_MUL,
    SEQ_SLEW_SUM,
    SEQ_SLEW_CLAMP,
    SEQ_FINISH
  } seq_state_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> sv/hmdr_in_if.sv
// Input tick channel: target mode, target duty and two ADC samples.
// Depends on hmdr_pkg.
`timescale 1ns / 1ps

interface hmdr_in_if
  import hmdr_pkg::*;
#(
  parameter int DUTY_BITS = 16,
  parameter int ADC_BITS  = 12
) ();
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    target_mode;
  logic [DUTY_BITS-1:0] target_duty;
  logic [ADC_BITS-1:0]  raw_left_current;
  logic [ADC_BITS-1:0]  raw_right_current;

  modport source (
    output valid, target_mode, target_duty, raw_left_current, raw_right_current,
    input  ready
  );
  modport sink (
    input  valid, target_mode, target_duty, raw_left_current, raw_right_current,
    output ready
  );
endinterface

>>> sv/hmdr_out_if.sv
// Result channel: PWM compare values, enable, mode and tick status.
// Depends on hmdr_pkg.
`timescale 1ns / 1ps

interface hmdr_out_if
  import hmdr_pkg::*;
#(
  parameter int DUTY_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [DUTY_BITS-1:0] left_duty;
  logic [DUTY_BITS-1:0] right_duty;
  logic                 enable_out;
  logic [MODE_W-1:0]    active_mode;
  logic [STATUS_W-1:0]  tick_status;

  modport source (
    output valid, left_duty, right_duty, enable_out, active_mode, tick_status,
    input  ready
  );
  modport sink (
    input  valid, left_duty, right_duty, enable_out, active_mode, tick_status,
    output ready
  );
endinterface

>>> sv/hmdr_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on hmdr_pkg.
`timescale 1ns / 1ps

interface hmdr_cfg_if
  import hmdr_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

>>> sv/hmdr_cfg_regs.sv
// Configuration register file of the duty regulator.
// Depends on hmdr_pkg.
`timescale 1ns / 1ps

module hmdr_cfg_regs
  import hmdr_pkg::*;
#(
  parameter int DUTY_BITS = 16,
  parameter int ADC_BITS  = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [CFG_DATA_W-1:0] wr_data_i,
  output logic [ADC_BITS-1:0]   cutoff_o,
  output logic [ADC_BITS-1:0]   limit_o,
  output logic [DUTY_BITS-1:0]  min_duty_o,
  output logic [DUTY_BITS-1:0]  max_duty_o,
  output logic [SLEW_W-1:0]     slew_o,
  output logic [SWITCH_W-1:0]   switch_ticks_o
);

  logic [ADC_BITS-1:0]  cutoff_q;
  logic [ADC_BITS-1:0]  limit_q;
  logic [DUTY_BITS-1:0] min_duty_q;
  logic [DUTY_BITS-1:0] max_duty_q;
  logic [SLEW_W-1:0]    slew_q;
  logic [SWITCH_W-1:0]  switch_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q       <= '1;
      limit_q        <= '1;
      min_duty_q     <= '0;
      max_duty_q     <= '1;
      slew_q         <= SLEW_W'(SLEW_RESET);
      switch_ticks_q <= SWITCH_W'(SWITCH_RESET);
    end else if (wr_en_i) begin
      case (cfg_reg_e'(wr_idx_i))
        CFG_CUTOFF:   cutoff_q       <= wr_data_i[ADC_BITS-1:0];
        CFG_LIMIT:    limit_q        <= wr_data_i[ADC_BITS-1:0];
        CFG_MIN_DUTY: min_duty_q     <= wr_data_i[DUTY_BITS-1:0];
        CFG_MAX_DUTY: max_duty_q     <= wr_data_i[DUTY_BITS-1:0];
        CFG_SLEW:     slew_q         <= wr_data_i[SLEW_W-1:0];
        CFG_SWITCH:   switch_ticks_q <= wr_data_i[SWITCH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cutoff_o       = cutoff_q;
  assign limit_o        = limit_q;
  assign min_duty_o     = min_duty_q;
  assign max_duty_o     = max_duty_q;
  assign slew_o         = slew_q;
  assign switch_ticks_o = switch_ticks_q;

endmodule

>>> sv/hmdr_div_unit.sv
// Serial restoring divider, one quotient bit per cycle, saturating quotient.
// Depends on hmdr_pkg.
`timescale 1ns / 1ps

module hmdr_div_unit
  import hmdr_pkg::*;
#(
  parameter int Q_W   = 16,
  parameter int DEN_W = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  div_ctrl_t              ctrl_i,
  input  logic [Q_W+DEN_W-1:0]   num_i,
  input  logic [DEN_W-1:0]       den_i,
  output logic [Q_W-1:0]         quo_o,
  output div_stat_t              stat_o
);

  localparam int NUM_W = Q_W + DEN_W;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [Q_W-1:0]   quo_q, quo_d;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             trial_ge;

  assign trial     = {rem_q, quo_q[Q_W-1]};
  assign trial_ge  = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (ctrl_i.start) begin
      den_d = den_i;
      rem_d = num_i[NUM_W-1:Q_W];
      quo_d = num_i[Q_W-1:0];
      if (num_i == '0) begin
        quo_d  = '0;
        done_d = 1'b1;
      end else if (den_i == '0 || num_i[NUM_W-1:Q_W] >= den_i) begin
        // quotient would not fit
        quo_d  = '1;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        cnt_d  = CNT_W'(Q_W);
      end
    end else if (busy_q) begin
      rem_d = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d = {quo_q[Q_W-2:0], trial_ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

>>> sv/hbridge_motor_duty_regulator_core.sv
// H-bridge duty regulator top level; uses hmdr_pkg, the channel interfaces,
// hmdr_cfg_regs and the serial divider hmdr_div_unit.
// After decide, a tick with no level recomputed (cutoff, switching, brake,
// disable) goes to finish; slewed: slew mul, sum, clamp; scaled: scale mul,
// num, div start, div wait (serial divider, one quotient bit per cycle).
// Finish waits on output stalls. One tick at a time. Async reset gives disable.
`timescale 1ns / 1ps

module hbridge_motor_duty_regulator_core
  import hmdr_pkg::*;
#(
  parameter int DUTY_BITS = 16,
  parameter int ADC_BITS  = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hmdr_cfg_if.sink  cfg_i,
  hmdr_in_if.sink   item_i,
  hmdr_out_if.source result_o
);

  localparam int PROD_W  = DUTY_BITS + ADC_BITS;
  localparam int DEN_W   = ADC_BITS + SCALE_GROW;
  localparam int NUM_W   = PROD_W + SCALE_GROW;
  localparam int SPROD_W = DUTY_BITS + SLEW_W + 2;
  localparam int SQ_W    = SPROD_W - SLEW_FRAC;
  localparam int V_W     = SQ_W + 1;

  // configuration
  logic [ADC_BITS-1:0]  cutoff_cur;
  logic [ADC_BITS-1:0]  limit_cur;
  logic [DUTY_BITS-1:0] min_duty;
  logic [DUTY_BITS-1:0] max_duty;
  logic [SLEW_W-1:0]    slew_cur;
  logic [SWITCH_W-1:0]  switch_ticks;

  // control state
  seq_state_e           state_q, state_d;
  mode_e                mode_now_q, mode_d;
  logic [SWITCH_W-1:0]  sw_cnt_q, cnt_d;
  logic [DUTY_BITS-1:0] left_q, left_d;
  logic [DUTY_BITS-1:0] right_q, right_d;
  logic                 en_q, en_d;
  logic                 out_valid_q;

  // tick payload and datapath
  mode_e                tgt_mode_q;
  logic [DUTY_BITS-1:0] tgt_duty_q;
  logic [ADC_BITS-1:0]  il_q;
  logic [ADC_BITS-1:0]  ir_q;
  logic [ADC_BITS-1:0]  cur_q, cur_d;
  logic                 drive_left_q, drive_left_d;
  status_e              status_q, status_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [NUM_W-1:0]     num_q, num_d;
  logic [DEN_W-1:0]     den_q, den_d;
  logic signed [SPROD_W-1:0] sprod_q, sprod_d;
  logic signed [V_W-1:0]     v_q, v_d;

  // result register
  logic [DUTY_BITS-1:0] out_left_q;
  logic [DUTY_BITS-1:0] out_right_q;
  logic                 out_en_q;
  mode_e                out_mode_q;
  status_e              out_status_q;

  logic                 in_xfer;
  logic                 out_free;
  logic                 out_load;
  logic                 cut_hit;
  logic                 lim_hit;
  logic                 mode_hit;
  logic                 sw_done;
  logic                 go_on;
  mode_e                eff_mode;
  logic [DUTY_BITS-1:0] lvl_drive;
  logic signed [DUTY_BITS:0] slew_diff;
  logic signed [SLEW_W:0]    slew_s;
  logic [SPROD_W-1:0]   sprod_bias;
  logic [SQ_W-1:0]      sq;
  logic                 v_gt_max;
  logic                 v_lt_min;
  logic [DUTY_BITS-1:0] clamp_val;
  div_ctrl_t            div_ctrl;
  div_stat_t            div_stat;
  logic [DUTY_BITS-1:0] div_quo;

  hmdr_cfg_regs #(
    .DUTY_BITS (DUTY_BITS),
    .ADC_BITS  (ADC_BITS)
  ) u_cfg_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_en_i        (cfg_i.valid),
    .wr_idx_i       (cfg_i.index),
    .wr_data_i      (cfg_i.data),
    .cutoff_o       (cutoff_cur),
    .limit_o        (limit_cur),
    .min_duty_o     (min_duty),
    .max_duty_o     (max_duty),
    .slew_o         (slew_cur),
    .switch_ticks_o (switch_ticks)
  );

  hmdr_div_unit #(
    .Q_W   (DUTY_BITS),
    .DEN_W (DEN_W)
  ) u_div_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (num_q),
    .den_i  (den_q),
    .quo_o  (div_quo),
    .stat_o (div_stat)
  );

  assign cfg_i.ready  = 1'b1;
  assign item_i.ready = (state_q == SEQ_IDLE) && !div_stat.busy;
  assign in_xfer      = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;

  assign cut_hit  = (il_q > cutoff_cur) || (ir_q > cutoff_cur);
  assign lim_hit  = (il_q > limit_cur) || (ir_q > limit_cur);
  assign mode_hit = (mode_now_q == tgt_mode_q);
  assign sw_done  = sw_cnt_q > switch_ticks;

  assign lvl_drive = drive_left_q ? left_q : right_q;

  // slew: level + trunc((target - level) * factor / 256)
  assign slew_diff  = $signed({1'b0, tgt_duty_q}) - $signed({1'b0, lvl_drive});
  assign slew_s     = $signed({1'b0, slew_cur});
  assign sprod_bias = sprod_q + (sprod_q[SPROD_W-1] ? SPROD_W'(SLEW_ONE - 1) : '0);
  assign sq         = sprod_bias[SPROD_W-1:SLEW_FRAC];

  assign v_gt_max = v_q > $signed({{(V_W-DUTY_BITS){1'b0}}, max_duty});
  assign v_lt_min = v_q < $signed({{(V_W-DUTY_BITS){1'b0}}, min_duty});

  always_comb begin
    if (v_gt_max) begin
      clamp_val = max_duty;
    end else if (v_q[V_W-1]) begin
      clamp_val = '0;
    end else if (v_lt_min) begin
      clamp_val = min_duty;
    end else begin
      clamp_val = v_q[DUTY_BITS-1:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_now_q;
    cnt_d        = sw_cnt_q;
    left_d       = left_q;
    right_d      = right_q;
    en_d         = en_q;
    status_d     = status_q;
    drive_left_d = drive_left_q;
    cur_d        = cur_q;
    prod_d       = prod_q;
    num_d        = num_q;
    den_d        = den_q;
    sprod_d      = sprod_q;
    v_d          = v_q;
    go_on        = 1'b0;
    eff_mode     = mode_now_q;
    div_ctrl     = '0;
    out_load     = 1'b0;
    case (state_q)
      SEQ_IDLE: begin
        if (in_xfer) state_d = SEQ_DECIDE;
      end
      SEQ_DECIDE: begin
        state_d = SEQ_FINISH;
        if (cut_hit) begin
          left_d   = '0;
          right_d  = '0;
          en_d     = 1'b0;
          status_d = ST_CUTOFF;
        end else if (!mode_hit) begin
          left_d   = '0;
          right_d  = '0;
          en_d     = 1'b1;
          status_d = ST_SWITCHING;
          if (tgt_mode_q == MODE_BRAKE) begin
            mode_d = MODE_BRAKE;
          end else if (tgt_mode_q == MODE_DISABLE) begin
            en_d   = 1'b0;
            mode_d = MODE_DISABLE;
          end else if (sw_done) begin
            mode_d   = tgt_mode_q;
            cnt_d    = '0;
            eff_mode = tgt_mode_q;
            go_on    = 1'b1;
          end else if (sw_cnt_q != '1) begin
            cnt_d = sw_cnt_q + SWITCH_W'(1);
          end
        end else begin
          go_on = 1'b1;
        end
        if (go_on) begin
          drive_left_d = (eff_mode == MODE_REVERSE);
          cur_d        = (eff_mode == MODE_REVERSE) ? il_q : ir_q;
          if (lim_hit) begin
            status_d = ST_LIMITED;
            if (eff_mode == MODE_FORWARD || eff_mode == MODE_REVERSE) begin
              state_d = SEQ_SCALE_MUL;
            end
          end else begin
            status_d = ST_REGULATED;
            if (eff_mode == MODE_FORWARD) begin
              left_d  = '0;
              state_d = SEQ_SLEW_MUL;
            end else if (eff_mode == MODE_REVERSE) begin
              right_d = '0;
              state_d = SEQ_SLEW_MUL;
            end
          end
        end
      end
      SEQ_SCALE_MUL: begin
        prod_d  = PROD_W'(lvl_drive) * PROD_W'(limit_cur);
        state_d = SEQ_SCALE_NUM;
      end
      SEQ_SCALE_NUM: begin
        // x9 and x10 as shift-add
        num_d   = (NUM_W'(prod_q) << 3) + NUM_W'(prod_q);
        den_d   = (DEN_W'(cur_q) << 3) + (DEN_W'(cur_q) << 1);
        state_d = SEQ_DIV_START;
      end
      SEQ_DIV_START: begin
        div_ctrl.start = 1'b1;
        state_d        = SEQ_DIV_WAIT;
      end
      SEQ_DIV_WAIT: begin
        if (div_stat.done) begin
          if (drive_left_q) begin
            left_d = div_quo;
          end else begin
            right_d = div_quo;
          end
          state_d = SEQ_FINISH;
        end
      end
      SEQ_SLEW_MUL: begin
        sprod_d = slew_diff * slew_s;
        state_d = SEQ_SLEW_SUM;
      end
      SEQ_SLEW_SUM: begin
        v_d     = $signed({{(V_W-DUTY_BITS){1'b0}}, lvl_drive}) + $signed({sq[SQ_W-1], sq});
        state_d = SEQ_SLEW_CLAMP;
      end
      SEQ_SLEW_CLAMP: begin
        if (drive_left_q) begin
          left_d = clamp_val;
        end else begin
          right_d = clamp_val;
        end
        state_d = SEQ_FINISH;
      end
      SEQ_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = SEQ_IDLE;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      mode_now_q  <= MODE_DISABLE;
      sw_cnt_q    <= '0;
      left_q      <= '0;
      right_q     <= '0;
      en_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_now_q <= mode_d;
      sw_cnt_q   <= cnt_d;
      left_q     <= left_d;
      right_q    <= right_d;
      en_q       <= en_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tgt_mode_q <= mode_e'(item_i.target_mode);
      tgt_duty_q <= item_i.target_duty;
      il_q       <= item_i.raw_left_current;
      ir_q       <= item_i.raw_right_current;
    end
    cur_q        <= cur_d;
    drive_left_q <= drive_left_d;
    status_q     <= status_d;
    prod_q       <= prod_d;
    num_q        <= num_d;
    den_q        <= den_d;
    sprod_q      <= sprod_d;
    v_q          <= v_d;
    if (out_load) begin
      out_left_q   <= left_q;
      out_right_q  <= right_q;
      out_en_q     <= en_q;
      out_mode_q   <= mode_now_q;
      out_status_q <= status_q;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.left_duty   = out_left_q;
  assign result_o.right_duty  = out_right_q;
  assign result_o.enable_out  = out_en_q;
  assign result_o.active_mode = out_mode_q;
  assign result_o.tick_status = out_status_q;

endmodule

>>> sv/hmdr_checker.sv
// Port-level checks of the duty regulator, bound to the top level.
// Depends on hmdr_pkg and hbridge_motor_duty_regulator_core_assert.svh.
`timescale 1ns / 1ps
`include "hbridge_motor_duty_regulator_core_assert.svh"

module hmdr_checker
  import hmdr_pkg::*;
#(
  parameter int DUTY_BITS = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [DUTY_BITS-1:0] left_duty_i,
  input logic [DUTY_BITS-1:0] right_duty_i,
  input logic                 enable_out_i,
  input logic [MODE_W-1:0]    active_mode_i,
  input logic [STATUS_W-1:0]  tick_status_i
);

  `HMDR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(left_duty_i) && $stable(right_duty_i) && $stable(tick_status_i),
    "result changed while stalled")

  `HMDR_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_valid_i && in_ready_i,
    !in_ready_i, "ready right after an input transfer")

  `HMDR_ASSERT_NOW(a_cutoff_off, clk_i, rst_ni, out_valid_i && tick_status_i == ST_CUTOFF,
    left_duty_i == '0 && right_duty_i == '0 && !enable_out_i,
    "cutoff tick left the bridge driven")

  `HMDR_ASSERT_NOW(a_fwd_left_zero, clk_i, rst_ni,
    out_valid_i && tick_status_i == ST_REGULATED && active_mode_i == MODE_FORWARD,
    left_duty_i == '0, "forward regulation with left duty set")

endmodule

bind hbridge_motor_duty_regulator_core hmdr_checker #(
  .DUTY_BITS (DUTY_BITS)
) u_hmdr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_i.valid),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .left_duty_i   (result_o.left_duty),
  .right_duty_i  (result_o.right_duty),
  .enable_out_i  (result_o.enable_out),
  .active_mode_i (result_o.active_mode),
  .tick_status_i (result_o.tick_status)
);

>>> test/hbridge_motor_duty_regulator_core_tb.sv
// Self-checking testbench for hbridge_motor_duty_regulator_core: directed and random
// control ticks, configuration sweeps, random stalls on both channels.
// Depends on hmdr_pkg and the hmdr_in_if, hmdr_out_if and hmdr_cfg_if interfaces.
`timescale 1ns / 1ps

module hbridge_motor_duty_regulator_core_tb;
  import hmdr_pkg::*;

  localparam int DUTY_W      = 16;
  localparam int ADC_W       = 12;
  localparam int LONG_HOLD   = 80;
  localparam int STUCK_LIMIT = 1000;
  localparam int SETTLE      = 4;
  localparam int TAIL_WAIT   = 26;

  typedef struct packed {
    mode_e             mode;
    logic [DUTY_W-1:0] duty;
    logic [ADC_W-1:0]  il;
    logic [ADC_W-1:0]  ir;
  } tick_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic              en;
    mode_e             mode;
    status_e           status;
  } duty_out_t;

  class bridge_tracker;
    logic [ADC_W-1:0]    cutoff;
    logic [ADC_W-1:0]    limit;
    logic [DUTY_W-1:0]   min_duty;
    logic [DUTY_W-1:0]   max_duty;
    logic [SLEW_W-1:0]   slew;
    logic [SWITCH_W-1:0] switch_ticks;
    logic [SWITCH_W-1:0] switch_cnt;
    mode_e               mode_now;
    logic [DUTY_W-1:0]   left_lvl;
    logic [DUTY_W-1:0]   right_lvl;
    logic                en_lvl;
    duty_out_t           pending_duties[$];
    int                  mismatches;

    function new();
      cutoff       = '1;
      limit        = '1;
      min_duty     = '0;
      max_duty     = '1;
      slew         = SLEW_W'(SLEW_RESET);
      switch_ticks = SWITCH_W'(SWITCH_RESET);
      switch_cnt   = '0;
      mode_now     = MODE_DISABLE;
      left_lvl     = '0;
      right_lvl    = '0;
      en_lvl       = 1'b0;
      mismatches   = 0;
    endfunction

    function void set_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] word);
      case (r)
        CFG_CUTOFF:   cutoff = word[ADC_W-1:0];
        CFG_LIMIT:    limit = word[ADC_W-1:0];
        CFG_MIN_DUTY: min_duty = word[DUTY_W-1:0];
        CFG_MAX_DUTY: max_duty = word[DUTY_W-1:0];
        CFG_SLEW:     slew = word[SLEW_W-1:0];
        CFG_SWITCH:   switch_ticks = word[SWITCH_W-1:0];
        default: ;
      endcase
    endfunction

    function void bridge_idle(logic en);
      left_lvl  = '0;
      right_lvl = '0;
      en_lvl    = en;
    endfunction

    function logic [DUTY_W-1:0] scaled(logic [DUTY_W-1:0] lvl, logic [ADC_W-1:0] cur);
      longint unsigned num;
      longint unsigned den;
      longint unsigned q;
      num = lvl;
      num = num * limit * 9;
      den = cur;
      den = den * 10;
      if (num == 0) return '0;
      if (den == 0) return '1;
      q = num / den;
      if ((q >> DUTY_W) != 0) return '1;
      return q[DUTY_W-1:0];
    endfunction

    function logic [DUTY_W-1:0] slewed(logic [DUTY_W-1:0] lvl, logic [DUTY_W-1:0] goal);
      longint here;
      longint v;
      longint sf;
      longint hi;
      longint lo;
      here = lvl;
      v    = goal;
      sf   = slew;
      hi   = max_duty;
      lo   = min_duty;
      // signed divide truncates toward zero
      v = here + ((v - here) * sf) / 256;
      if (v > hi) return max_duty;
      if (v < 0) return '0;
      if (v < lo) return min_duty;
      return v[DUTY_W-1:0];
    endfunction

    function void note_tick(tick_t t);
      duty_out_t want;
      status_e   st;
      logic      engaged;
      engaged = 1'b0;
      st      = ST_SWITCHING;
      if (t.il > cutoff || t.ir > cutoff) begin
        bridge_idle(1'b0);
        st = ST_CUTOFF;
      end else if (mode_now != t.mode) begin
        if (t.mode == MODE_BRAKE || t.mode == MODE_DISABLE) begin
          bridge_idle(t.mode == MODE_BRAKE);
          mode_now = t.mode;
        end else begin
          bridge_idle(1'b1);
          if (switch_cnt > switch_ticks) begin
            mode_now   = t.mode;
            switch_cnt = '0;
            engaged    = 1'b1;
          end else if (switch_cnt != '1) begin
            switch_cnt++;
          end
        end
      end else begin
        engaged = 1'b1;
      end
      if (engaged) begin
        if (t.il > limit || t.ir > limit) begin
          st = ST_LIMITED;
          if (mode_now == MODE_FORWARD) right_lvl = scaled(right_lvl, t.ir);
          else if (mode_now == MODE_REVERSE) left_lvl = scaled(left_lvl, t.il);
        end else begin
          st = ST_REGULATED;
          if (mode_now == MODE_FORWARD) begin
            left_lvl  = '0;
            right_lvl = slewed(right_lvl, t.duty);
          end else if (mode_now == MODE_REVERSE) begin
            right_lvl = '0;
            left_lvl  = slewed(left_lvl, t.duty);
          end
        end
      end
      want = '{left_lvl, right_lvl, en_lvl, mode_now, st};
      pending_duties.push_back(want);
    endfunction

    function void check_duty(duty_out_t got);
      duty_out_t want;
      if (pending_duties.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: left %0d right %0d en %0d mode %0d status %0d",
                   got.left_duty, got.right_duty, got.en, got.mode, got.status);
        return;
      end
      want = pending_duties.pop_front();
      if (got.left_duty !== want.left_duty || got.right_duty !== want.right_duty ||
          got.en !== want.en || got.mode !== want.mode || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t mismatch: left %0d/%0d right %0d/%0d en %0d/%0d mode %0d/%0d st %0d/%0d",
                   $realtime, want.left_duty, got.left_duty, want.right_duty, got.right_duty,
                   want.en, got.en, want.mode, got.mode, want.status, got.status);
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  hmdr_cfg_if cfg ();
  hmdr_in_if #(.DUTY_BITS(DUTY_W), .ADC_BITS(ADC_W)) item ();
  hmdr_out_if #(.DUTY_BITS(DUTY_W)) res ();

  hbridge_motor_duty_regulator_core #(
    .DUTY_BITS(DUTY_W),
    .ADC_BITS (ADC_W)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .item_i  (item),
    .result_o(res)
  );

  bridge_tracker tracker = new();
  bit            quiet = 1'b0;
  bit            hold_req = 1'b0;
  mode_e         aim = MODE_DISABLE;
  int            stuck_cycles = 0;
  duty_out_t     seen;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      seen.left_duty  = res.left_duty;
      seen.right_duty = res.right_duty;
      seen.en         = res.enable_out;
      seen.mode       = mode_e'(res.active_mode);
      seen.status     = status_e'(res.tick_status);
      tracker.check_duty(seen);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (item.valid && item.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      stuck_cycles = 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck_cycles++;
    end
  end

  // result receiver with random and long holds
  initial begin
    int stall;
    stall = 0;
    res.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LONG_HOLD;
      end else if (stall == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 8);
      end
      if (stall > 0) begin
        res.ready <= 1'b0;
        stall--;
      end else begin
        res.ready <= 1'b1;
      end
      @(posedge clk_i);
    end
  end

  task automatic send_tick(mode_e m, logic [DUTY_W-1:0] duty, logic [ADC_W-1:0] il,
                           logic [ADC_W-1:0] ir);
    tick_t t;
    t = '{m, duty, il, ir};
    item.valid             <= 1'b1;
    item.target_mode       <= m;
    item.target_duty       <= duty;
    item.raw_left_current  <= il;
    item.raw_right_current <= ir;
    do @(posedge clk_i); while (!item.ready);
    tracker.note_tick(t);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    item.valid <= 1'b0;
    while (tracker.pending_duties.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic configure(int unsigned cut, int unsigned lim, int unsigned mn,
                           int unsigned mx, int unsigned sl, int unsigned sw);
    int unsigned           vals[6];
    cfg_reg_e              r;
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] word;
    int                    w;
    vals = '{cut, lim, mn, mx, sl, sw};
    for (int k = 0; k < 6; k++) begin
      r = cfg_reg_e'(k);
      case (r)
        CFG_CUTOFF, CFG_LIMIT: w = ADC_W;
        CFG_SLEW:              w = SLEW_W;
        default:               w = DUTY_W;
      endcase
      mask = (32'd1 << w) - 1;
      word = (vals[k] & mask) | ($urandom() & ~mask);
      cfg.valid <= 1'b1;
      cfg.index <= r;
      cfg.data  <= word;
      do @(posedge clk_i); while (!cfg.ready);
      tracker.set_reg(r, word);
    end
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [ADC_W-1:0] pick_current();
    int unsigned floor_thr;
    floor_thr = (tracker.limit < tracker.cutoff) ? tracker.limit : tracker.cutoff;
    case ($urandom_range(0, 9))
      7, 8: begin
        if (tracker.limit < '1)
          return ADC_W'($urandom_range(tracker.limit + 1, (1 << ADC_W) - 1));
        return ADC_W'($urandom_range(0, (1 << ADC_W) - 1));
      end
      9: return ADC_W'($urandom_range(0, (1 << ADC_W) - 1));
      default: return ADC_W'($urandom_range(0, floor_thr));
    endcase
  endfunction

  function automatic logic [DUTY_W-1:0] pick_duty();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return DUTY_W'($urandom_range(0, (1 << DUTY_W) - 1));
    endcase
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) aim = mode_e'($urandom_range(0, 3));
      send_tick(aim, pick_duty(), pick_current(), pick_current());
    end
  endtask

  initial begin
    item.valid             <= 1'b0;
    item.target_mode       <= MODE_DISABLE;
    item.target_duty       <= '0;
    item.raw_left_current  <= '0;
    item.raw_right_current <= '0;
    cfg.valid              <= 1'b0;
    cfg.index              <= CFG_CUTOFF;
    cfg.data               <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration
    send_tick(MODE_DISABLE, 16'd0, 12'd4095, 12'd4095);
    send_tick(MODE_BRAKE, 16'd65535, 12'd0, 12'd0);
    send_tick(MODE_FORWARD, 16'd1234, 12'd10, 12'd20);
    drain();
    configure(3000, 2000, 100, 60000, 256, 1);
    send_tick(MODE_FORWARD, 16'd65535, 12'd0, 12'd0);
    send_tick(MODE_FORWARD, 16'd65535, 12'd0, 12'd0);
    send_tick(MODE_FORWARD, 16'd0, 12'd0, 12'd0);
    send_tick(MODE_FORWARD, 16'd40000, 12'd0, 12'd2500);
    send_tick(MODE_FORWARD, 16'd50000, 12'd5, 12'd5);
    // only the idle side above the limit, driving current zero
    send_tick(MODE_FORWARD, 16'd50000, 12'd2500, 12'd0);
    send_tick(MODE_FORWARD, 16'd1000, 12'd2001, 12'd2001);
    send_tick(MODE_FORWARD, 16'd1000, 12'd3001, 12'd0);
    send_tick(MODE_FORWARD, 16'd30000, 12'd3000, 12'd2000);
    send_tick(MODE_REVERSE, 16'd30000, 12'd0, 12'd0);
    send_tick(MODE_REVERSE, 16'd30000, 12'd0, 12'd0);
    send_tick(MODE_REVERSE, 16'd65535, 12'd0, 12'd0);
    send_tick(MODE_REVERSE, 16'd20000, 12'd2500, 12'd0);
    send_tick(MODE_REVERSE, 16'd20000, 12'd0, 12'd2500);
    send_tick(MODE_BRAKE, 16'd20000, 12'd0, 12'd0);
    send_tick(MODE_BRAKE, 16'd20000, 12'd100, 12'd100);
    // counter kept across an abandoned switch
    send_tick(MODE_FORWARD, 16'd20000, 12'd0, 12'd0);
    send_tick(MODE_DISABLE, 16'd20000, 12'd0, 12'd0);
    send_tick(MODE_FORWARD, 16'd20000, 12'd0, 12'd0);
    send_tick(MODE_FORWARD, 16'd20001, 12'd0, 12'd0);
    drain();
    // min above max
    configure(4095, 4095, 50000, 20000, 128, 0);
    send_tick(MODE_FORWARD, 16'd65535, 12'd0, 12'd0);
    send_tick(MODE_FORWARD, 16'd1, 12'd0, 12'd0);

    aim = MODE_FORWARD;
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: configure(4000, 3500, 0, 65535, 256, 2);
        1: configure(3000, 1500, 1000, 50000, 64, 0);
        2: configure(0, 0, 0, 0, 0, 0);
        3: configure(4095, 4095, 65535, 65535, 511, 65535);
        6: begin
          quiet = 1'b1;
          configure(3800, 2500, 200, 64000, 200, 1);
        end
        default: configure($urandom_range(1000, 4095), $urandom_range(500, 4095),
                           $urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 511), $urandom_range(0, 5));
      endcase
      run_random(30);
      if (ph == 0) hold_req = 1'b1;
      else if (ph == 1) drain();
      run_random((ph == 3) ? 5 : 30);
    end

    drain();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_duties.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
